FILE: hdl/dtt_pkg.sv
`timescale 1ns / 1ps
package dtt_pkg;
    localparam int SLOTS_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MODIFY = 3'd2,
        OP_UPSERT = 3'd3,
        OP_TICK   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] OPK_CMD  = 2'd0;
    localparam logic [1:0] OPK_TICK = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_EMIT,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, start scan
        logic scan_find; // scan for id (0: expiry)
        logic step;      // advance scan index
        logic act;       // apply operation on scan result
        logic fire;      // apply fire to best expired slot
        logic clr_done;  // reset per-tick done marks
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
        logic found;
        logic [1:0] op_kind; // OPK_CMD or OPK_TICK
    } t_stat;
endpackage

FILE: hdl/deadline_timer_table.sv
`timescale 1ns / 1ps
// Deadline timer table.
// Slave channel carries one request: operation, timer id, interval, repeat.
// Master channel returns results: kind, fired id, status, with tlast on the
// final result of each request.
// The slots are scanned one per cycle. A command or an empty tick is scanned,
// then acted on, and then its result is presented. A tick that fires presents
// its first result after two scans (one to find the first expired timer, one
// more to find the next); each further fired timer costs another fire step
// and scan after the previous result is taken. A request is taken only when
// the previous one is done.
// Reset clears all slots, the current time and the stamp counter.
// While the receiver stalls, the result holds and no request is accepted.
module deadline_timer_table #(
    parameter int TIMER_SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operation[2:0], timer_id, interval_ms, repeat_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // fired_id[31:0], status[33:32]
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);
    dtt_pkg::t_cmd  cmd;
    dtt_pkg::t_stat stat;
    logic [31:0] fired_id;
    logic [1:0]  status, kind;
    logic        fired;

    dtt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_kind(kind), .o_last(m_axis_tlast),
        .o_cmd(cmd), .i_stat(stat)
    );

    dtt_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_op(s_axis_tdata[2:0]), .i_id(s_axis_tdata[34:3]),
        .i_interval(s_axis_tdata[58:35]), .i_repeat(s_axis_tdata[59]),
        .o_stat(stat), .o_fired_id(fired_id), .o_status(status)
    );

    assign fired = (kind == dtt_pkg::KIND_FIRED);
    assign m_axis_tuser = kind;
    // status only means something on command results
    assign m_axis_tdata = {6'd0, (kind == dtt_pkg::KIND_DONE) ? status : dtt_pkg::ST_OK,
                           fired ? fired_id : 32'd0};
endmodule

FILE: hdl/dtt_datapath.sv
`timescale 1ns / 1ps
module dtt_datapath #(
    parameter int TIMER_SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dtt_pkg::t_cmd         i_cmd,
    input  logic [2:0]            i_op,
    input  logic [31:0]           i_id,
    input  logic [23:0]           i_interval,
    input  logic                  i_repeat,
    output dtt_pkg::t_stat        o_stat,
    output logic [31:0]           o_fired_id,
    output logic [1:0]            o_status
);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    logic [TIMER_SLOTS-1:0] r_valid, n_valid, r_done, n_done;
    logic [31:0] r_sid [TIMER_SLOTS];
    logic [31:0] r_dl  [TIMER_SLOTS];
    logic [23:0] r_iv  [TIMER_SLOTS];
    logic        r_rp  [TIMER_SLOTS];
    logic [31:0] r_st  [TIMER_SLOTS];
    logic [31:0] r_now, r_stampc;
    logic [2:0]  r_op;
    logic [31:0] r_id;
    logic [23:0] r_ivq;
    logic        r_rpq;
    logic [CW-1:0] r_idx;
    logic        r_has;
    logic [IW-1:0] r_best;
    logic [31:0] r_fid;
    logic [1:0]  r_status;

    logic [IW-1:0] idx;
    logic [31:0] k_c, k_b, ds;
    logic prec, cand, free_any;
    logic [IW-1:0] free_idx;

    assign idx = r_idx[IW-1:0];
    assign k_c = r_dl[idx] - r_now;
    assign k_b = r_dl[r_best] - r_now;
    assign ds  = r_st[idx] - r_st[r_best];
    // indices scan upward, so a tie on key and stamp keeps the older best
    always_comb begin
        if (k_c != k_b) prec = (k_c ^ 32'h8000_0000) < (k_b ^ 32'h8000_0000);
        else            prec = (ds != 32'd0) && !ds[31];
    end

    always_comb begin
        cand = 1'b0;
        if (r_idx < CW'(TIMER_SLOTS) && r_valid[idx]) begin
            if (i_cmd.scan_find) cand = (r_sid[idx] == r_id);
            else cand = !r_done[idx] && ((k_c == 32'd0) || k_c[31]);
        end
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_any = 1'b1;
                free_idx = IW'(s);
            end
        end
    end

    assign o_stat.scan_end = (r_idx >= CW'(TIMER_SLOTS - 1));
    assign o_stat.found    = r_has;
    assign o_stat.op_kind  = (r_op == dtt_pkg::OP_TICK) ? dtt_pkg::OPK_TICK : dtt_pkg::OPK_CMD;
    assign o_fired_id = r_fid;
    assign o_status   = r_status;

    always_comb begin
        n_valid = r_valid;
        n_done  = r_done;
        if (i_cmd.clr_done) n_done = '0;
        if (i_cmd.fire) begin
            n_done[r_best] = 1'b1;
            if (!r_rp[r_best]) n_valid[r_best] = 1'b0;
        end
        if (i_cmd.act) begin
            unique case (r_op)
                dtt_pkg::OP_INSERT: if (free_any) n_valid[free_idx] = 1'b1;
                dtt_pkg::OP_REMOVE: if (r_has) n_valid[r_best] = 1'b0;
                dtt_pkg::OP_UPSERT: if (!r_has && free_any) n_valid[free_idx] = 1'b1;
                dtt_pkg::OP_CLEAR:  n_valid = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_done   <= '0;
            r_now    <= '0;
            r_stampc <= '0;
            r_idx    <= '0;
            r_has    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
            if (i_cmd.load) begin
                r_op  <= i_op;
                r_id  <= i_id;
                r_ivq <= i_interval;
                r_rpq <= i_repeat;
                if (i_op == dtt_pkg::OP_TICK) r_now <= r_now + 32'd1;
            end
            if (i_cmd.load || i_cmd.fire) begin
                r_idx <= '0;
                r_has <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + CW'(1);
                if (cand && (!r_has || prec)) begin
                    r_has  <= 1'b1;
                    r_best <= idx;
                end
            end
            if (i_cmd.fire) begin
                r_fid <= r_sid[r_best];
                if (r_rp[r_best]) begin
                    r_dl[r_best] <= r_now + 32'(r_iv[r_best]);
                    r_st[r_best] <= r_stampc;
                    r_stampc <= r_stampc + 32'd1;
                end
            end
            if (i_cmd.act) begin
                r_status <= dtt_pkg::ST_OK;
                r_fid    <= '0;
                case (r_op)
                    dtt_pkg::OP_INSERT, dtt_pkg::OP_UPSERT: begin
                        if (r_op == dtt_pkg::OP_UPSERT && r_has) begin
                            r_rp[r_best] <= 1'b0;
                            r_dl[r_best] <= r_now + 32'(r_ivq);
                            r_iv[r_best] <= r_ivq;
                            r_st[r_best] <= r_stampc;
                            r_stampc <= r_stampc + 32'd1;
                        end else if (free_any) begin
                            r_sid[free_idx] <= r_id;
                            r_rp[free_idx]  <= (r_op == dtt_pkg::OP_INSERT) && r_rpq;
                            r_dl[free_idx]  <= r_now + 32'(r_ivq);
                            r_iv[free_idx]  <= r_ivq;
                            r_st[free_idx]  <= r_stampc;
                            r_stampc <= r_stampc + 32'd1;
                        end else begin
                            r_status <= dtt_pkg::ST_FULL;
                        end
                    end
                    dtt_pkg::OP_REMOVE: if (!r_has) r_status <= dtt_pkg::ST_NOTFOUND;
                    dtt_pkg::OP_MODIFY: begin
                        if (!r_has) r_status <= dtt_pkg::ST_NOTFOUND;
                        else begin
                            r_dl[r_best] <= r_now + 32'(r_ivq);
                            r_iv[r_best] <= r_ivq;
                            r_st[r_best] <= r_stampc;
                            r_stampc <= r_stampc + 32'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> r_valid[r_best])
        else $error("fire on free slot");
    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.act && i_cmd.fire))
        else $error("act and fire together");
    a_now_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_op != dtt_pkg::OP_TICK) |=> $stable(r_now))
        else $error("time moved without tick");
endmodule

FILE: hdl/dtt_ctrl.sv
`timescale 1ns / 1ps
module dtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic           o_last,
    output dtt_pkg::t_cmd  o_cmd,
    input  dtt_pkg::t_stat i_stat
);
    localparam int FW = 5;
    dtt_pkg::t_state r_state, n_state;
    logic [FW-1:0] r_nfired, n_nfired;
    logic [1:0] r_kind, n_kind;
    logic r_last, n_last;
    logic r_tick, n_tick;
    logic fire_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dtt_pkg::S_IDLE;
            r_nfired <= '0;
            r_kind   <= '0;
            r_last   <= 1'b0;
            r_tick   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nfired <= n_nfired;
            r_kind   <= n_kind;
            r_last   <= n_last;
            r_tick   <= n_tick;
        end
    end

    // a fired result is the last one when no further expired slot was found
    // or the per-tick fire bound is reached
    assign fire_last = !i_stat.found || (r_nfired >= FW'(16));

    assign o_kind = r_kind;
    assign o_last = (r_kind == dtt_pkg::KIND_FIRED) ? fire_last : r_last;

    always_comb begin
        n_state  = r_state;
        n_nfired = r_nfired;
        n_kind   = r_kind;
        n_last   = r_last;
        n_tick   = r_tick;
        o_cmd    = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.scan_find = !r_tick;
        unique case (r_state)
            dtt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr_done = 1'b1;
                    n_nfired = '0;
                    n_state = dtt_pkg::S_SCAN;
                end
            end
            dtt_pkg::S_SCAN: begin
                n_tick = (i_stat.op_kind == dtt_pkg::OPK_TICK);
                o_cmd.scan_find = (i_stat.op_kind != dtt_pkg::OPK_TICK);
                o_cmd.step = 1'b1;
                if (i_stat.scan_end) n_state = dtt_pkg::S_ACT;
            end
            dtt_pkg::S_ACT: begin
                if (r_tick) begin
                    if (i_stat.found) begin
                        o_cmd.fire = 1'b1;
                        n_nfired = r_nfired + FW'(1);
                        n_kind = dtt_pkg::KIND_FIRED;
                        n_last = 1'b0;
                        n_state = dtt_pkg::S_EMIT;
                    end else if (r_nfired == '0) begin
                        n_kind = dtt_pkg::KIND_IDLE;
                        n_last = 1'b1;
                        n_state = dtt_pkg::S_OUT;
                    end else begin
                        n_state = dtt_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.act = 1'b1;
                    n_kind = dtt_pkg::KIND_DONE;
                    n_last = 1'b1;
                    n_state = dtt_pkg::S_OUT;
                end
            end
            dtt_pkg::S_EMIT: begin
                // fired result waits while the next expiry scan runs
                o_cmd.scan_find = 1'b0;
                o_cmd.step = 1'b1;
                if (i_stat.scan_end) n_state = dtt_pkg::S_OUT;
            end
            dtt_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_kind == dtt_pkg::KIND_FIRED && !fire_last)
                        n_state = dtt_pkg::S_ACT;
                    else
                        n_state = dtt_pkg::S_IDLE;
                end
            end
            default: n_state = dtt_pkg::S_IDLE;
        endcase
    end

    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("overlap");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfired <= FW'(16)) else $error("fire bound");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == dtt_pkg::S_IDLE) else $error("load busy");
endmodule
